/* design/bthk_pkg.sv */
// Shared types, constants and helpers of the bounded top-K max-heap unit.
// No dependencies; imported by bthk_seq and bounded_top_k_max_heap_unit.
package bthk_pkg;

  // Heap capacity and derived widths
  localparam int MAX_KEEP   = 256;
  localparam int ADDR_W     = $clog2(MAX_KEEP);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int IDX_W      = ADDR_W + 2;
  localparam int KEY_W      = 32;
  localparam int COORD_W    = 32;
  localparam int ORIENT_W   = 3;
  localparam int SLOT_W     = 8;
  localparam int LIMIT_W    = 9;
  localparam int KEEP_RESET = 200;

  // Opcodes carried on in_tuser
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Action codes carried on out_tuser
  localparam logic [2:0] ACT_INSERT  = 3'd0;
  localparam logic [2:0] ACT_REPLACE = 3'd1;
  localparam logic [2:0] ACT_REJECT  = 3'd2;
  localparam logic [2:0] ACT_READ    = 3'd3;
  localparam logic [2:0] ACT_CLEAR   = 3'd4;
  localparam logic [2:0] ACT_BADSLOT = 3'd5;

  // One heap entry as stored in the RAM
  typedef struct packed {
    logic [ORIENT_W-1:0] orient;
    logic [COORD_W-1:0]  z;
    logic [COORD_W-1:0]  x;
    logic [KEY_W-1:0]    key;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // RAM access issued by the sequencer
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // Finished result handed to the output register
  typedef struct packed {
    logic [2:0]       action;
    logic [CNT_W-1:0] kept_count;
    logic [KEY_W-1:0] worst_key;
    entry_t           rd;
  } res_t;

  // Parent slot of a non-root slot
  function automatic logic [ADDR_W-1:0] f_parent(input logic [ADDR_W-1:0] i);
    logic [ADDR_W-1:0] im1;
    im1 = i - ADDR_W'(1);
    return im1 >> 1;
  endfunction

  // Left child slot, wide enough to compare against the count
  function automatic logic [IDX_W-1:0] f_left(input logic [ADDR_W-1:0] i);
    return {1'b0, i, 1'b1};
  endfunction

endpackage

/* design/bounded_top_k_max_heap_unit.sv */
// Top level of the bounded top-K max-heap unit: ports, limit register,
// output register. Depends on bthk_pkg, bthk_seq and bthk_ram.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in_     | input     | in_tvalid / in_tready  | opcode on tuser, hit in tdata
//  out_    | output    | out_tvalid / out_tready| action on tuser, result tdata
//  cfg_    | input     | cfg_valid / cfg_ready  | keep_limit on cfg_data
//
// One transaction at a time; in_tready is low while an operation runs.
// Push append moves the new item up level by level; push replace sifts it down,
// reading the left then the right child of each level through the single read
// port of the entry RAM. Read fetches one slot; clear resets the entry count.
// A finished result waits in the output register; the next transaction is taken
// meanwhile and only its own result stalls on out_tready.
// Reset (rst_n low, synchronous) empties the heap and sets keep_limit to 200.
module bounded_top_k_max_heap_unit (
  input  logic         clk,
  input  logic         rst_n,
  // tuser: opcode[1:0]
  // tdata: hit_x[31:0], hit_z[63:32], hit_orient[66:64], hit_key[98:67],
  //        slot_index[106:99], zero[111:107]
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,
  input  logic [111:0] in_tdata,
  // tuser: action[2:0]
  // tdata: kept_count[8:0], worst_key[40:9], read_x[72:41], read_z[104:73],
  //        read_orient[107:105], read_key[139:108], zero[143:140]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [2:0]   out_tuser,
  output logic [143:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [8:0]   cfg_data
);
  import bthk_pkg::*;

  logic [LIMIT_W-1:0] limit_r, limit_nxt;
  logic [CNT_W-1:0]   cap;
  entry_t             in_item;
  logic [SLOT_W-1:0]  in_slot;
  logic               out_free;
  logic               res_valid;
  res_t               res;
  ram_req_t           ram_req;
  entry_t             ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;
  logic               out_valid_r, out_valid_nxt;
  res_t               out_res_r, out_res_nxt;

  // Unpack the input transaction
  assign in_item.x      = in_tdata[31:0];
  assign in_item.z      = in_tdata[63:32];
  assign in_item.orient = in_tdata[66:64];
  assign in_item.key    = in_tdata[98:67];
  assign in_slot        = in_tdata[106:99];

  // Limit register, always writable
  assign cfg_ready = 1'b1;
  always_comb begin
    limit_nxt = limit_r;
    if (cfg_valid) begin
      limit_nxt = cfg_data;
    end
  end

  // Effective capacity: zero acts as one, clipped to the RAM depth
  always_comb begin
    priority if (limit_r == '0) begin
      cap = CNT_W'(1);
    end else if (32'(limit_r) > MAX_KEEP) begin
      cap = CNT_W'(MAX_KEEP);
    end else begin
      cap = CNT_W'(limit_r);
    end
  end

  bthk_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_item   (in_item),
    .in_slot   (in_slot),
    .cap       (cap),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  bthk_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_KEEP)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  // Output register
  assign out_free = !out_valid_r || out_tready;
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_W'(KEEP_RESET);
      out_valid_r <= 1'b0;
    end else begin
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  // Pack the result transaction
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.action;
  assign out_tdata  = {4'b0, out_res_r.rd.key, out_res_r.rd.orient, out_res_r.rd.z,
                       out_res_r.rd.x, out_res_r.worst_key, out_res_r.kept_count};

endmodule

/* design/bthk_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the heap entries of the top-K unit.
module bthk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/bthk_seq.sv */
// Heap sequencer: runs push/sift, read and clear over the entry RAM with
// one shared key comparator. Depends on bthk_pkg; drives a bthk_ram.
module bthk_seq (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_op,
  input  bthk_pkg::entry_t         in_item,
  input  logic [bthk_pkg::SLOT_W-1:0] in_slot,
  input  logic [bthk_pkg::CNT_W-1:0]  cap,
  input  logic                     out_free,
  output logic                     res_valid,
  output bthk_pkg::res_t           res,
  output bthk_pkg::ram_req_t       ram_req,
  input  bthk_pkg::entry_t         ram_rdata
);
  import bthk_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_UP      = 7'b0000010,
    ST_DN_L    = 7'b0000100,
    ST_DN_R    = 7'b0001000,
    ST_WR_ITEM = 7'b0010000,
    ST_RD_WAIT = 7'b0100000,
    ST_FIN     = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [KEY_W-1:0]  root_key_r, root_key_nxt;
  entry_t            item_r, item_nxt;
  entry_t            best_r, best_nxt;
  logic              lgt_r, lgt_nxt;
  logic              r_ok_r, r_ok_nxt;
  logic [2:0]        act_r, act_nxt;
  entry_t            rd_r, rd_nxt;

  // Shared comparator: cmp_gt = cmp_a > cmp_b
  logic [KEY_W-1:0]  cmp_a, cmp_b;
  logic              cmp_gt;

  assign cmp_gt = cmp_a > cmp_b;

  // Operand selection for the comparator
  always_comb begin
    unique case (state_r)
      ST_IDLE: begin
        cmp_a = root_key_r;
        cmp_b = in_item.key;
      end
      ST_UP: begin
        cmp_a = item_r.key;
        cmp_b = ram_rdata.key;
      end
      ST_DN_L: begin
        cmp_a = ram_rdata.key;
        cmp_b = item_r.key;
      end
      ST_DN_R: begin
        cmp_a = ram_rdata.key;
        cmp_b = lgt_r ? best_r.key : item_r.key;
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
  end

  // Sequencer next state and RAM requests
  always_comb begin
    logic [ADDR_W-1:0] par;
    logic [IDX_W-1:0]  lft;
    logic [IDX_W-1:0]  rgt;
    logic [ADDR_W-1:0] child;
    logic [IDX_W-1:0]  lft2;
    logic              take_r;

    state_nxt = state_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    item_nxt  = item_r;
    best_nxt  = best_r;
    lgt_nxt   = lgt_r;
    r_ok_nxt  = r_ok_r;
    act_nxt   = act_r;
    rd_nxt    = rd_r;
    ram_req   = '0;
    res_valid = 1'b0;
    par       = f_parent(idx_r);
    lft       = f_left(idx_r);
    rgt       = lft + IDX_W'(1);
    child     = '0;
    lft2      = '0;
    take_r    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_item;
          rd_nxt   = '0;
          unique case (in_op)
            OP_PUSH: begin
              if (cnt_r < cap) begin
                // Append at the end, hole sifts up from there
                idx_nxt = cnt_r[ADDR_W-1:0];
                cnt_nxt = cnt_r + CNT_W'(1);
                act_nxt = ACT_INSERT;
                if (cnt_r == '0) begin
                  ram_req.we    = 1'b1;
                  ram_req.waddr = '0;
                  ram_req.wdata = in_item;
                  state_nxt     = ST_FIN;
                end else begin
                  ram_req.re    = 1'b1;
                  ram_req.raddr = f_parent(cnt_r[ADDR_W-1:0]);
                  state_nxt     = ST_UP;
                end
              end else if (cmp_gt) begin
                // Full: new key is below the root key, hole sifts down from root
                idx_nxt = '0;
                act_nxt = ACT_REPLACE;
                if (cnt_r > CNT_W'(1)) begin
                  ram_req.re    = 1'b1;
                  ram_req.raddr = ADDR_W'(1);
                  state_nxt     = ST_DN_L;
                end else begin
                  ram_req.we    = 1'b1;
                  ram_req.waddr = '0;
                  ram_req.wdata = in_item;
                  state_nxt     = ST_FIN;
                end
              end else begin
                act_nxt   = ACT_REJECT;
                state_nxt = ST_FIN;
              end
            end
            OP_READ: begin
              if (32'(in_slot) < 32'(cnt_r)) begin
                ram_req.re    = 1'b1;
                ram_req.raddr = ADDR_W'(in_slot);
                act_nxt       = ACT_READ;
                state_nxt     = ST_RD_WAIT;
              end else begin
                act_nxt   = ACT_BADSLOT;
                state_nxt = ST_FIN;
              end
            end
            OP_CLEAR: begin
              cnt_nxt   = '0;
              act_nxt   = ACT_CLEAR;
              state_nxt = ST_FIN;
            end
            default: begin
              act_nxt   = ACT_REJECT;
              state_nxt = ST_FIN;
            end
          endcase
        end
      end

      ST_UP: begin
        // Parent data is back; move it down if it is smaller than the item
        ram_req.we = 1'b1;
        if (cmp_gt) begin
          ram_req.waddr = idx_r;
          ram_req.wdata = ram_rdata;
          idx_nxt       = par;
          if (par == '0) begin
            state_nxt = ST_WR_ITEM;
          end else begin
            ram_req.re    = 1'b1;
            ram_req.raddr = f_parent(par);
          end
        end else begin
          ram_req.waddr = idx_r;
          ram_req.wdata = item_r;
          state_nxt     = ST_FIN;
        end
      end

      ST_DN_L: begin
        // Left child data is back; fetch the right child if present
        best_nxt = ram_rdata;
        lgt_nxt  = cmp_gt;
        r_ok_nxt = rgt < IDX_W'(cnt_r);
        if (rgt < IDX_W'(cnt_r)) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = rgt[ADDR_W-1:0];
        end
        state_nxt = ST_DN_R;
      end

      ST_DN_R: begin
        take_r     = r_ok_r && cmp_gt;
        ram_req.we = 1'b1;
        if (take_r || lgt_r) begin
          // Larger child moves up into the hole
          child         = take_r ? rgt[ADDR_W-1:0] : lft[ADDR_W-1:0];
          ram_req.waddr = idx_r;
          ram_req.wdata = take_r ? ram_rdata : best_r;
          idx_nxt       = child;
          lft2          = f_left(child);
          if (lft2 < IDX_W'(cnt_r)) begin
            ram_req.re    = 1'b1;
            ram_req.raddr = lft2[ADDR_W-1:0];
            state_nxt     = ST_DN_L;
          end else begin
            state_nxt = ST_WR_ITEM;
          end
        end else begin
          ram_req.waddr = idx_r;
          ram_req.wdata = item_r;
          state_nxt     = ST_FIN;
        end
      end

      ST_WR_ITEM: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = idx_r;
        ram_req.wdata = item_r;
        state_nxt     = ST_FIN;
      end

      ST_RD_WAIT: begin
        rd_nxt    = ram_rdata;
        state_nxt = ST_FIN;
      end

      ST_FIN: begin
        if (out_free) begin
          res_valid = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Mirror of the root key, tracks every write to slot zero
  always_comb begin
    root_key_nxt = root_key_r;
    if (ram_req.we && ram_req.waddr == '0) begin
      root_key_nxt = ram_req.wdata.key;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    root_key_r <= root_key_nxt;
    item_r     <= item_nxt;
    best_r     <= best_nxt;
    lgt_r      <= lgt_nxt;
    r_ok_r     <= r_ok_nxt;
    act_r      <= act_nxt;
    rd_r       <= rd_nxt;
  end

  assign in_ready       = (state_r == ST_IDLE);
  assign res.action     = act_r;
  assign res.kept_count = cnt_r;
  assign res.worst_key  = (cnt_r != '0) ? root_key_r : '0;
  assign res.rd         = rd_r;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= MAX_KEEP)
    else $error("entry count above capacity");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr))
    else $error("RAM read and write to the same slot in one cycle");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_op == OP_PUSH && cnt_r < cap)
      |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("append did not grow the heap by one");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_op == OP_CLEAR) |=> (cnt_r == '0))
    else $error("clear left entries in the heap");
`endif

endmodule
